>>> rtl/replacement_template_parser_macros.svh
// Assertion macros for the replacement template parser.
// Included by the RTL files that carry assertions; expects clk and rst_n in scope.
`ifndef REPLACEMENT_TEMPLATE_PARSER_MACROS_SVH
`define REPLACEMENT_TEMPLATE_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RTP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("replacement_template_parser assertion failed");
`define RTP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("replacement_template_parser assertion failed");
`else
`define RTP_ASSERT(lbl, prop)
`define RTP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/rtp_pkg.sv
// Shared types and constants for the replacement template parser.
// No dependencies; used by every other RTL file of the block except rtp_if.sv.
package rtp_pkg;

  localparam int unsigned MAX_CAPTURES_DEF = 64;
  localparam int unsigned CFG_W            = 7;
  localparam int unsigned RES_MAX          = 3;
  localparam int unsigned FIFO_DEPTH       = 4;
  localparam int unsigned FIFO_PW          = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW          = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [1:0] KIND_LIT  = 2'd0;
  localparam logic [1:0] KIND_REF  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [2:0] ERR_BAD_ESCAPE    = 3'd0;
  localparam logic [2:0] ERR_ESCAPE_AT_END = 3'd1;
  localparam logic [2:0] ERR_DOLLAR_AT_END = 3'd2;
  localparam logic [2:0] ERR_NONDIGIT      = 3'd3;
  localparam logic [2:0] ERR_UNCLOSED      = 3'd4;
  localparam logic [2:0] ERR_NO_DIGITS     = 3'd5;

  typedef enum logic [5:0] {
    MODE_NORMAL = 6'b000001,
    MODE_ESC    = 6'b000010,
    MODE_DOLLAR = 6'b000100,
    MODE_BRACE  = 6'b001000,
    MODE_DIGITS = 6'b010000,
    MODE_SKIP   = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [5:0] capture_index;
    logic [2:0] error_code;
    logic       last;
  } result_t;

  // Results produced by one parse step, item[0] first.
  typedef struct packed {
    logic [1:0]                cnt;
    result_t [RES_MAX-1:0]     item;
  } res_bundle_t;

  function automatic result_t make_result(logic [1:0] kind, logic [7:0] byte_val,
                                          logic [5:0] idx, logic [2:0] err,
                                          logic last);
    result_t r;
    r.kind          = kind;
    r.out_byte      = byte_val;
    r.capture_index = idx;
    r.error_code    = err;
    r.last          = last;
    return r;
  endfunction

endpackage

>>> rtl/rtp_if.sv
// Valid/ready channel interfaces for the template bytes and the parse results.
// Depends on nothing; payload widths are fixed by the field definitions.
interface rtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] format_byte;
  logic       is_final;

  modport source (output valid, output format_byte, output is_final, input ready);
  modport sink   (input valid, input format_byte, input is_final, output ready);
endinterface

interface rtp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [5:0] capture_index;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output kind, output out_byte, output capture_index,
                  output error_code, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input capture_index,
                  input error_code, input last, output ready);
endinterface

>>> rtl/replacement_template_parser.sv
// Replacement template parser: one template byte per transfer in, literal,
// capture-reference, done and error results out.
// Path: a byte waits in the input register, and its results go through the result queue.
// Throughput: one byte per cycle while each byte yields at most one result and the
// receiver does not stall; a byte yielding more results is still taken whole, and
// later bytes then wait in the input register until the result queue has room.
// Reset (synchronous, active low): normal text mode, capture count 0, queue empty.
`include "replacement_template_parser_macros.svh"

module replacement_template_parser #(
  parameter int unsigned MAX_CAPTURES = rtp_pkg::MAX_CAPTURES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [rtp_pkg::CFG_W-1:0] cfg_wr_data,
  rtp_in_if.sink                    in_ch,
  rtp_out_if.source                 out_ch
);

  logic                      in_vld_r, in_vld_nxt;
  logic [7:0]                in_byte_r;
  logic                      in_fin_r;
  logic [rtp_pkg::CFG_W-1:0] cap_cnt_r;
  logic                      room;
  logic                      advance;
  logic                      in_xfer;
  rtp_pkg::res_bundle_t      res;

  assign advance     = in_vld_r && room;
  assign in_ch.ready = !in_vld_r || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_vld_nxt  = in_xfer || (in_vld_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      cap_cnt_r <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (cfg_wr_en) begin
        cap_cnt_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_ch.format_byte;
      in_fin_r  <= in_ch.is_final;
    end
  end

  rtp_parse #(
    .MAX_CAPTURES(MAX_CAPTURES)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .byte_in      (in_byte_r),
    .fin          (in_fin_r),
    .capture_count(cap_cnt_r),
    .res          (res)
  );

  rtp_result_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res),
    .room  (room),
    .out_ch(out_ch)
  );

  `RTP_ASSERT(a_hold_until_advance, (in_vld_r && !advance) |=> in_vld_r)
  `RTP_ASSERT(a_push_only_on_advance, (res.cnt != 2'd0) |-> advance)

endmodule

>>> rtl/rtp_parse.sv
// Parse state machine: holds the mode, index accumulator and digit flag, and
// turns one template byte into up to three results. Depends on rtp_pkg.
`include "replacement_template_parser_macros.svh"

module rtp_parse #(
  parameter int unsigned MAX_CAPTURES = rtp_pkg::MAX_CAPTURES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [7:0]                byte_in,
  input  logic                      fin,
  input  logic [rtp_pkg::CFG_W-1:0] capture_count,
  output rtp_pkg::res_bundle_t      res
);

  localparam int unsigned AW = $clog2(MAX_CAPTURES + 1);
  localparam int unsigned PW = AW + 4;
  localparam int unsigned CW = (AW > rtp_pkg::CFG_W) ? AW : rtp_pkg::CFG_W;

  rtp_pkg::mode_t mode_r, mode_nxt;
  logic [AW-1:0]  acc_r, acc_nxt;
  logic           digit_seen_r, digit_seen_nxt;

  logic           is_digit;
  logic [AW-1:0]  acc_base;
  logic [PW-1:0]  prod;
  logic [AW-1:0]  acc_new;
  logic [CW-1:0]  cnt_eff;
  logic           ok_old;
  logic           ok_new;
  logic           do_normal;
  logic [1:0]     n;
  rtp_pkg::res_bundle_t bun;

  function automatic logic [5:0] idx_of(logic [AW-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    return w[5:0];
  endfunction

  assign is_digit = (byte_in >= rtp_pkg::CH_ZERO) && (byte_in <= rtp_pkg::CH_NINE);

  // A dollar starts a fresh value, so the first digit accumulates onto zero.
  assign acc_base = (mode_r == rtp_pkg::MODE_DOLLAR) ? '0 : acc_r;
  assign prod     = PW'(acc_base) * PW'(10) + PW'(byte_in[3:0]);
  assign acc_new  = (prod > PW'(MAX_CAPTURES)) ? AW'(MAX_CAPTURES) : prod[AW-1:0];

  assign cnt_eff  = (CW'(capture_count) > CW'(MAX_CAPTURES)) ? CW'(MAX_CAPTURES)
                                                              : CW'(capture_count);
  assign ok_old   = CW'(acc_r) < cnt_eff;
  assign ok_new   = CW'(acc_new) < cnt_eff;

  always_comb begin
    mode_nxt       = mode_r;
    acc_nxt        = acc_r;
    digit_seen_nxt = digit_seen_r;
    do_normal      = 1'b0;
    n              = 2'd0;
    bun            = '0;

    unique case (mode_r)
      rtp_pkg::MODE_NORMAL: begin
        do_normal = 1'b1;
      end
      rtp_pkg::MODE_ESC: begin
        if (byte_in != rtp_pkg::CH_BSLASH && byte_in != rtp_pkg::CH_DOLLAR) begin
          mode_nxt = fin ? rtp_pkg::MODE_NORMAL : rtp_pkg::MODE_SKIP;
          bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_ERR, 8'd0, 6'd0,
                                             rtp_pkg::ERR_BAD_ESCAPE, 1'b1);
          n = n + 2'd1;
        end else begin
          mode_nxt = rtp_pkg::MODE_NORMAL;
          bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_LIT, byte_in, 6'd0, 3'd0, 1'b0);
          n = n + 2'd1;
          if (fin) begin
            bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_DONE, 8'd0, 6'd0, 3'd0, 1'b1);
            n = n + 2'd1;
          end
        end
      end
      rtp_pkg::MODE_DOLLAR: begin
        acc_nxt        = '0;
        digit_seen_nxt = 1'b0;
        if (byte_in == rtp_pkg::CH_LBRACE) begin
          if (fin) begin
            mode_nxt = rtp_pkg::MODE_NORMAL;
            bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_ERR, 8'd0, 6'd0,
                                               rtp_pkg::ERR_UNCLOSED, 1'b1);
            n = n + 2'd1;
          end else begin
            mode_nxt = rtp_pkg::MODE_BRACE;
          end
        end else if (!is_digit) begin
          mode_nxt = fin ? rtp_pkg::MODE_NORMAL : rtp_pkg::MODE_SKIP;
          bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_ERR, 8'd0, 6'd0,
                                             rtp_pkg::ERR_NO_DIGITS, 1'b1);
          n = n + 2'd1;
        end else begin
          acc_nxt        = acc_new;
          digit_seen_nxt = 1'b1;
          if (fin) begin
            mode_nxt = rtp_pkg::MODE_NORMAL;
            if (ok_new) begin
              bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_REF, 8'd0, idx_of(acc_new),
                                                 3'd0, 1'b0);
              n = n + 2'd1;
            end
            bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_DONE, 8'd0, 6'd0, 3'd0, 1'b1);
            n = n + 2'd1;
          end else begin
            mode_nxt = rtp_pkg::MODE_DIGITS;
          end
        end
      end
      rtp_pkg::MODE_BRACE: begin
        if (byte_in == rtp_pkg::CH_RBRACE) begin
          if (!digit_seen_r) begin
            mode_nxt = fin ? rtp_pkg::MODE_NORMAL : rtp_pkg::MODE_SKIP;
            bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_ERR, 8'd0, 6'd0,
                                               rtp_pkg::ERR_NO_DIGITS, 1'b1);
            n = n + 2'd1;
          end else begin
            mode_nxt = rtp_pkg::MODE_NORMAL;
            if (ok_old) begin
              bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_REF, 8'd0, idx_of(acc_r),
                                                 3'd0, 1'b0);
              n = n + 2'd1;
            end
            if (fin) begin
              bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_DONE, 8'd0, 6'd0, 3'd0, 1'b1);
              n = n + 2'd1;
            end
          end
        end else if (!is_digit) begin
          mode_nxt = fin ? rtp_pkg::MODE_NORMAL : rtp_pkg::MODE_SKIP;
          bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_ERR, 8'd0, 6'd0,
                                             rtp_pkg::ERR_NONDIGIT, 1'b1);
          n = n + 2'd1;
        end else begin
          acc_nxt        = acc_new;
          digit_seen_nxt = 1'b1;
          if (fin) begin
            mode_nxt = rtp_pkg::MODE_NORMAL;
            bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_ERR, 8'd0, 6'd0,
                                               rtp_pkg::ERR_UNCLOSED, 1'b1);
            n = n + 2'd1;
          end
        end
      end
      rtp_pkg::MODE_DIGITS: begin
        if (is_digit) begin
          acc_nxt = acc_new;
          if (fin) begin
            mode_nxt = rtp_pkg::MODE_NORMAL;
            if (ok_new) begin
              bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_REF, 8'd0, idx_of(acc_new),
                                                 3'd0, 1'b0);
              n = n + 2'd1;
            end
            bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_DONE, 8'd0, 6'd0, 3'd0, 1'b1);
            n = n + 2'd1;
          end
        end else begin
          // The reference closes first; the terminating byte is then plain text.
          if (ok_old) begin
            bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_REF, 8'd0, idx_of(acc_r),
                                               3'd0, 1'b0);
            n = n + 2'd1;
          end
          do_normal = 1'b1;
        end
      end
      rtp_pkg::MODE_SKIP: begin
        if (fin) begin
          mode_nxt = rtp_pkg::MODE_NORMAL;
        end
      end
      default: begin
        do_normal = 1'b1;
      end
    endcase

    if (do_normal) begin
      if (byte_in == rtp_pkg::CH_BSLASH) begin
        if (fin) begin
          mode_nxt = rtp_pkg::MODE_NORMAL;
          bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_ERR, 8'd0, 6'd0,
                                             rtp_pkg::ERR_ESCAPE_AT_END, 1'b1);
          n = n + 2'd1;
        end else begin
          mode_nxt = rtp_pkg::MODE_ESC;
        end
      end else if (byte_in == rtp_pkg::CH_DOLLAR) begin
        if (fin) begin
          mode_nxt = rtp_pkg::MODE_NORMAL;
          bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_ERR, 8'd0, 6'd0,
                                             rtp_pkg::ERR_DOLLAR_AT_END, 1'b1);
          n = n + 2'd1;
        end else begin
          mode_nxt       = rtp_pkg::MODE_DOLLAR;
          acc_nxt        = '0;
          digit_seen_nxt = 1'b0;
        end
      end else begin
        mode_nxt = rtp_pkg::MODE_NORMAL;
        bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_LIT, byte_in, 6'd0, 3'd0, 1'b0);
        n = n + 2'd1;
        if (fin) begin
          bun.item[n] = rtp_pkg::make_result(rtp_pkg::KIND_DONE, 8'd0, 6'd0, 3'd0, 1'b1);
          n = n + 2'd1;
        end
      end
    end

    bun.cnt = step ? n : 2'd0;
    res     = bun;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= rtp_pkg::MODE_NORMAL;
      acc_r        <= '0;
      digit_seen_r <= 1'b0;
    end else if (step) begin
      mode_r       <= mode_nxt;
      acc_r        <= acc_nxt;
      digit_seen_r <= digit_seen_nxt;
    end
  end

  `RTP_ASSERT(a_acc_saturated, acc_r <= AW'(MAX_CAPTURES))
  `RTP_ASSERT(a_skip_silent, (mode_r == rtp_pkg::MODE_SKIP) |-> (res.cnt == 2'd0))
  `RTP_ASSERT(a_final_ends, (step && fin && mode_r != rtp_pkg::MODE_SKIP) |->
    ((res.cnt == 2'd1 && res.item[0].last) || (res.cnt == 2'd2 && res.item[1].last) ||
     (res.cnt == 2'd3 && res.item[2].last)))

endmodule

>>> rtl/rtp_result_fifo.sv
// Result queue: takes up to three results per cycle and hands them out one
// transfer at a time on the result channel. Depends on rtp_pkg and rtp_if.
`include "replacement_template_parser_macros.svh"

module rtp_result_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rtp_pkg::res_bundle_t push,
  output logic                 room,
  rtp_out_if.source            out_ch
);

  rtp_pkg::result_t                   mem_r [rtp_pkg::FIFO_DEPTH];
  logic [rtp_pkg::FIFO_PW-1:0]        rd_r, rd_nxt;
  logic [rtp_pkg::FIFO_PW-1:0]        wr_r, wr_nxt;
  logic [rtp_pkg::FIFO_CW-1:0]        cnt_r, cnt_nxt;
  logic                               pop;
  rtp_pkg::result_t                   head;

  assign pop  = out_ch.valid && out_ch.ready;
  // Space for a worst-case step must exist before the parser may advance.
  assign room = cnt_r <= rtp_pkg::FIFO_CW'(rtp_pkg::FIFO_DEPTH - rtp_pkg::RES_MAX);

  assign head                 = mem_r[rd_r];
  assign out_ch.valid         = cnt_r != '0;
  assign out_ch.kind          = head.kind;
  assign out_ch.out_byte      = head.out_byte;
  assign out_ch.capture_index = head.capture_index;
  assign out_ch.error_code    = head.error_code;
  assign out_ch.last          = head.last;

  always_comb begin
    rd_nxt  = rd_r + rtp_pkg::FIFO_PW'(pop);
    wr_nxt  = wr_r + rtp_pkg::FIFO_PW'(push.cnt);
    cnt_nxt = cnt_r + rtp_pkg::FIFO_CW'(push.cnt) - rtp_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < rtp_pkg::RES_MAX; k++) begin
      if (2'(k) < push.cnt) begin
        mem_r[wr_r + rtp_pkg::FIFO_PW'(k)] <= push.item[k];
      end
    end
  end

  `RTP_ASSERT(a_no_overflow, (push.cnt != 2'd0) |->
    ((cnt_r + rtp_pkg::FIFO_CW'(push.cnt)) <= rtp_pkg::FIFO_CW'(rtp_pkg::FIFO_DEPTH)))
  `RTP_ASSERT(a_cnt_tracks_ptrs, (cnt_r == '0) |-> (rd_r == wr_r))

endmodule

>>> verif/rtp_result_checker.sv
// Result checker for the replacement template parser: watches both channels,
// predicts the results of each byte transfer and compares them in order.
// Depends on rtp_pkg and the channel interfaces in rtp_if.sv.
module rtp_result_checker #(
  parameter int unsigned MAX_CAPTURES = rtp_pkg::MAX_CAPTURES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [rtp_pkg::CFG_W-1:0] cfg_wr_data,
  rtp_in_if                         in_ch,
  rtp_out_if                        out_ch,
  output int                        mismatches,
  output int                        outstanding
);

  logic [rtp_pkg::CFG_W-1:0] capture_limit;
  rtp_pkg::mode_t            mode;
  int unsigned               index_acc;
  logic                      digit_seen;
  rtp_pkg::result_t          pending_results[$];

  function automatic void queue_result(logic [1:0] kind, logic [7:0] value,
                                       logic [5:0] idx, logic [2:0] err, logic last);
    rtp_pkg::result_t r;
    r.kind          = kind;
    r.out_byte      = value;
    r.capture_index = idx;
    r.error_code    = err;
    r.last          = last;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void queue_done();
    queue_result(rtp_pkg::KIND_DONE, 8'h00, 6'd0, 3'd0, 1'b1);
  endfunction

  // An error ends the template; bytes up to the final one are then dropped.
  function automatic void queue_error(logic [2:0] code, logic fin);
    mode = fin ? rtp_pkg::MODE_NORMAL : rtp_pkg::MODE_SKIP;
    queue_result(rtp_pkg::KIND_ERR, 8'h00, 6'd0, code, 1'b1);
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= rtp_pkg::CH_ZERO && b <= rtp_pkg::CH_NINE;
  endfunction

  function automatic void accumulate(logic [7:0] b);
    int unsigned v;
    v = index_acc * 10 + 32'(b - rtp_pkg::CH_ZERO);
    index_acc = (v > MAX_CAPTURES) ? MAX_CAPTURES : v;
  endfunction

  function automatic void queue_capture();
    int unsigned usable;
    usable = (capture_limit > MAX_CAPTURES) ? MAX_CAPTURES : capture_limit;
    if (index_acc < usable) begin
      queue_result(rtp_pkg::KIND_REF, 8'h00, 6'(index_acc), 3'd0, 1'b0);
    end
  endfunction

  function automatic void plain_text(logic [7:0] b, logic fin);
    if (b == rtp_pkg::CH_BSLASH) begin
      if (fin) queue_error(rtp_pkg::ERR_ESCAPE_AT_END, fin);
      else mode = rtp_pkg::MODE_ESC;
    end else if (b == rtp_pkg::CH_DOLLAR) begin
      if (fin) queue_error(rtp_pkg::ERR_DOLLAR_AT_END, fin);
      else begin
        mode       = rtp_pkg::MODE_DOLLAR;
        index_acc  = 0;
        digit_seen = 1'b0;
      end
    end else begin
      mode = rtp_pkg::MODE_NORMAL;
      queue_result(rtp_pkg::KIND_LIT, b, 6'd0, 3'd0, 1'b0);
      if (fin) queue_done();
    end
  endfunction

  function automatic void parse_template_byte(logic [7:0] b, logic fin);
    case (mode)
      rtp_pkg::MODE_ESC: begin
        if (b != rtp_pkg::CH_BSLASH && b != rtp_pkg::CH_DOLLAR) begin
          queue_error(rtp_pkg::ERR_BAD_ESCAPE, fin);
        end else begin
          mode = rtp_pkg::MODE_NORMAL;
          queue_result(rtp_pkg::KIND_LIT, b, 6'd0, 3'd0, 1'b0);
          if (fin) queue_done();
        end
      end
      rtp_pkg::MODE_DOLLAR: begin
        index_acc  = 0;
        digit_seen = 1'b0;
        if (b == rtp_pkg::CH_LBRACE) begin
          if (fin) queue_error(rtp_pkg::ERR_UNCLOSED, fin);
          else mode = rtp_pkg::MODE_BRACE;
        end else if (!is_digit(b)) begin
          queue_error(rtp_pkg::ERR_NO_DIGITS, fin);
        end else begin
          accumulate(b);
          digit_seen = 1'b1;
          if (fin) begin
            mode = rtp_pkg::MODE_NORMAL;
            queue_capture();
            queue_done();
          end else begin
            mode = rtp_pkg::MODE_DIGITS;
          end
        end
      end
      rtp_pkg::MODE_BRACE: begin
        if (b == rtp_pkg::CH_RBRACE) begin
          if (!digit_seen) queue_error(rtp_pkg::ERR_NO_DIGITS, fin);
          else begin
            mode = rtp_pkg::MODE_NORMAL;
            queue_capture();
            if (fin) queue_done();
          end
        end else if (!is_digit(b)) begin
          queue_error(rtp_pkg::ERR_NONDIGIT, fin);
        end else begin
          accumulate(b);
          digit_seen = 1'b1;
          if (fin) queue_error(rtp_pkg::ERR_UNCLOSED, fin);
        end
      end
      rtp_pkg::MODE_DIGITS: begin
        if (is_digit(b)) begin
          accumulate(b);
          if (fin) begin
            mode = rtp_pkg::MODE_NORMAL;
            queue_capture();
            queue_done();
          end
        end else begin
          // The byte that ends a bare reference is then parsed as plain text.
          queue_capture();
          plain_text(b, fin);
        end
      end
      rtp_pkg::MODE_SKIP: begin
        if (fin) mode = rtp_pkg::MODE_NORMAL;
      end
      default: plain_text(b, fin);
    endcase
  endfunction

  function automatic string describe(rtp_pkg::result_t r);
    return $sformatf("kind=%0d byte=%02h index=%0d error=%0d last=%0d",
                     r.kind, r.out_byte, r.capture_index, r.error_code, r.last);
  endfunction

  always @(posedge clk) begin
    rtp_pkg::result_t got;
    rtp_pkg::result_t want;
    if (!rst_n) begin
      capture_limit = '0;
      mode          = rtp_pkg::MODE_NORMAL;
      index_acc     = 0;
      digit_seen    = 1'b0;
      pending_results.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) parse_template_byte(in_ch.format_byte, in_ch.is_final);
      if (out_ch.valid && out_ch.ready) begin
        got.kind          = out_ch.kind;
        got.out_byte      = out_ch.out_byte;
        got.capture_index = out_ch.capture_index;
        got.error_code    = out_ch.error_code;
        got.last          = out_ch.last;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result transfer with nothing pending: %s", describe(got));
          end
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
              got.capture_index !== want.capture_index ||
              got.error_code !== want.error_code || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected %s", describe(want));
              $display("                 actual   %s", describe(got));
            end
          end
        end
      end
      // A register write takes effect for the bytes that follow it.
      if (cfg_wr_en) capture_limit = cfg_wr_data;
    end
    outstanding = pending_results.size();
  end

endmodule

>>> verif/tb_replacement_template_parser.sv
// Testbench top for the replacement template parser: clock, reset, template
// stimulus with random idling on both channels, and the final verdict.
// Depends on rtp_pkg, rtp_if.sv, the parser RTL and rtp_result_checker.
module tb_replacement_template_parser;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [rtp_pkg::CFG_W-1:0] cfg_wr_data;
  bit                        jitter;
  int                        hold_requests;
  int                        holds_done;
  int                        bytes_sent;
  int                        quiet_cycles;
  int                        mismatches;
  int                        outstanding;
  logic [7:0]                template_bytes[$];

  rtp_in_if  in_ch();
  rtp_out_if out_ch();

  replacement_template_parser DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  rtp_result_checker result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  // Receiver: random stalls, or a long hold-off so the input side backs up.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done <= hold_requests;
      end else if (jitter) begin
        out_ch.ready <= ($urandom_range(0, 99) >= 34);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // All tasks below are entered right after a rising edge.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (jitter && $urandom_range(0, 99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.format_byte <= b;
    in_ch.is_final    <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_queued();
    foreach (template_bytes[i]) send_byte(template_bytes[i], i == template_bytes.size() - 1);
  endtask

  function automatic void add_byte(input logic [7:0] b);
    template_bytes.insert(template_bytes.size(), b);
  endfunction

  task automatic send_text(input string s);
    template_bytes.delete();
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    send_queued();
  endtask

  function automatic void push_digits();
    repeat ($urandom_range(1, 3)) add_byte(rtp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  // Mostly well-formed pieces with random content, some malformed ones.
  task automatic send_random_template();
    int         pick;
    logic [7:0] b;
    template_bytes.delete();
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        do b = 8'($urandom_range(0, 255));
        while (b == rtp_pkg::CH_BSLASH || b == rtp_pkg::CH_DOLLAR);
        add_byte(b);
      end else if (pick < 47) begin
        add_byte(rtp_pkg::CH_BSLASH);
        add_byte($urandom_range(0, 1) ? rtp_pkg::CH_BSLASH : rtp_pkg::CH_DOLLAR);
      end else if (pick < 66) begin
        add_byte(rtp_pkg::CH_DOLLAR);
        push_digits();
      end else if (pick < 86) begin
        add_byte(rtp_pkg::CH_DOLLAR);
        add_byte(rtp_pkg::CH_LBRACE);
        if ($urandom_range(0, 9) != 0) push_digits();
        add_byte(rtp_pkg::CH_RBRACE);
      end else begin
        add_byte($urandom_range(0, 1) ? rtp_pkg::CH_BSLASH : rtp_pkg::CH_DOLLAR);
        if ($urandom_range(0, 1)) add_byte(rtp_pkg::CH_LBRACE);
        add_byte(8'($urandom_range(0, 255)));
      end
    end
    send_queued();
  endtask

  task automatic set_capture_count(input logic [rtp_pkg::CFG_W-1:0] count);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // A byte can be in flight with no result yet, so wait a little past the drain.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input logic [rtp_pkg::CFG_W-1:0] count, input bit calm,
                           input bit hold, input int n);
    int target;
    jitter <= !calm;
    set_capture_count(count);
    if (hold) hold_requests <= hold_requests + 1;
    target = bytes_sent + n;
    while (bytes_sent < target) send_random_template();
    settle();
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.format_byte <= '0;
    in_ch.is_final    <= 1'b0;
    jitter            <= 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    set_capture_count(7'd10);
    send_byte(8'h00, 1'b1);
    send_text("\377");
    send_text("\\\\\\$");
    send_text("$3a");
    send_text("${7}");
    send_text("$99");
    send_text("\\q");
    send_text("\\");
    send_text("$");
    send_text("${a}");
    send_text("${5");
    send_text("${}");
    send_text("$x");
    send_text("${");
    settle();

    run_phase(7'd0, 1'b0, 1'b0, 40);
    run_phase(7'd64, 1'b0, 1'b1, 60);
    run_phase(7'd1, 1'b1, 1'b0, 50);
    run_phase(7'($urandom_range(2, 63)), 1'b0, 1'b0, 60);
    run_phase(7'd64, 1'b0, 1'b0, 60);

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rtp_pkg.sv
rtl/rtp_if.sv
rtl/rtp_parse.sv
rtl/rtp_result_fifo.sv
rtl/replacement_template_parser.sv
verif/rtp_result_checker.sv
verif/tb_replacement_template_parser.sv
